FILE: hw/rtl/ghb_pkg.sv
// shared types, constants and control store for the grade histogram binner
`default_nettype none
package ghb_pkg;

  // grade range and field widths
  localparam int GRADE_TOP     = 100;
  localparam int BIN_W         = 7;
  localparam int GRADE_W       = 16;
  localparam int OUT_COUNT_W   = 32;
  localparam int LINE_W        = 32;
  localparam int DIV_W         = 7;
  localparam int DIV_CNT_W     = 3;
  localparam logic [BIN_W-1:0] NUM_BINS_RESET = 7'd10;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_GRADE  = 2'd1,
    ST_UNUSED_BIN = 2'd2
  } status_t;

  // request and response payloads
  typedef struct packed {
    logic                      mode;
    logic signed [GRADE_W-1:0] grade;
    logic [BIN_W-1:0]          bin_select;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [BIN_W-1:0]       bin_index;
    logic [OUT_COUNT_W-1:0] bin_count;
    logic [LINE_W-1:0]      line_number;
  } rsp_t;

  // microprogram steps
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_CHECK,
    S_DIV,
    S_ADDR,
    S_UPDATE,
    S_READ,
    S_RDOUT,
    S_BAD,
    S_EMIT
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_REQ,
    COND_READ,
    COND_BAD,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  // bin index register source
  typedef enum logic [1:0] {
    IDX_NONE,
    IDX_BIN,
    IDX_SEL
  } idx_src_t;

  // result register update kind
  typedef enum logic [1:0] {
    RES_HOLD,
    RES_GRADE,
    RES_READ,
    RES_BAD
  } res_kind_t;

  // one control word
  typedef struct packed {
    logic      in_ready;
    logic      line_inc;
    logic      div_init;
    logic      div_step;
    idx_src_t  idx_load;
    res_kind_t res;
    logic      emit;
    cond_t     cond;
    step_t     jump;
    step_t     next;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic req_valid;
    logic is_read;
    logic is_bad;
    logic div_more;
    logic out_busy;
  } seq_stat_t;

  // bin width 100 / n for n bins in use
  function automatic logic [BIN_W-1:0] bin_width(input logic [BIN_W-1:0] n);
    logic [BIN_W-1:0] w;
    case (n) inside
      7'd1:            w = 7'd100;
      7'd2:            w = 7'd50;
      7'd3:            w = 7'd33;
      7'd4:            w = 7'd25;
      7'd5:            w = 7'd20;
      7'd6:            w = 7'd16;
      7'd7:            w = 7'd14;
      7'd8:            w = 7'd12;
      7'd9:            w = 7'd11;
      7'd10:           w = 7'd10;
      7'd11:           w = 7'd9;
      7'd12:           w = 7'd8;
      [7'd13:7'd14]:   w = 7'd7;
      [7'd15:7'd16]:   w = 7'd6;
      [7'd17:7'd20]:   w = 7'd5;
      [7'd21:7'd25]:   w = 7'd4;
      [7'd26:7'd33]:   w = 7'd3;
      [7'd34:7'd50]:   w = 7'd2;
      default:         w = 7'd1;
    endcase
    return w;
  endfunction

  // control store
  function automatic ctrl_t ucode_rom(input step_t s);
    ctrl_t w;
    w      = '0;
    w.cond = COND_NEVER;
    w.jump = S_IDLE;
    w.next = S_IDLE;
    case (s)
      S_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = COND_NO_REQ;
        w.jump     = S_IDLE;
        w.next     = S_DISPATCH;
      end
      S_DISPATCH: begin
        w.line_inc = 1'b1;
        w.cond     = COND_READ;
        w.jump     = S_READ;
        w.next     = S_CHECK;
      end
      S_CHECK: begin
        w.div_init = 1'b1;
        w.cond     = COND_BAD;
        w.jump     = S_BAD;
        w.next     = S_DIV;
      end
      S_DIV: begin
        w.div_step = 1'b1;
        w.cond     = COND_DIV_MORE;
        w.jump     = S_DIV;
        w.next     = S_ADDR;
      end
      S_ADDR: begin
        w.idx_load = IDX_BIN;
        w.next     = S_UPDATE;
      end
      S_UPDATE: begin
        w.res  = RES_GRADE;
        w.next = S_EMIT;
      end
      S_READ: begin
        w.idx_load = IDX_SEL;
        w.next     = S_RDOUT;
      end
      S_RDOUT: begin
        w.res  = RES_READ;
        w.next = S_EMIT;
      end
      S_BAD: begin
        w.res  = RES_BAD;
        w.next = S_EMIT;
      end
      S_EMIT: begin
        w.emit = 1'b1;
        w.cond = COND_OUT_BUSY;
        w.jump = S_EMIT;
        w.next = S_IDLE;
      end
      default: begin
        w.next = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ghb_if.sv
// valid/ready stream interface with a typed payload
`default_nettype none
interface ghb_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ghb_ram.sv
// generic single write port ram with registered read
`default_nettype none
module ghb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ghb_div.sv
// restoring divider, one quotient bit per step
`default_nettype none
module ghb_div
  import ghb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             init,
  input  wire logic             step,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic      [DIV_W-1:0] quotient,
  output logic                  more
);

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] left;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       diff;
  logic                 ge;

  // trial subtract
  always_comb begin
    rem_sh = {rem, quo[DIV_W-1]};
    ge     = (rem_sh >= {1'b0, divisor});
    diff   = rem_sh - {1'b0, divisor};
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (init) begin
      left <= DIV_CNT_W'(DIV_W);
    end else if (step && (left != '0)) begin
      left <= left - 1'b1;
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (init) begin
      rem <= '0;
      quo <= dividend;
    end else if (step) begin
      rem <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign quotient = quo;
  assign more     = (left != DIV_CNT_W'(1));

endmodule
`default_nettype wire

FILE: hw/rtl/ghb_useq.sv
// microprogram sequencer: step counter, control store and jump logic
`default_nettype none
module ghb_useq
  import ghb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire seq_stat_t stat,
  output ctrl_t          ctrl
);

  step_t step;
  step_t step_next;
  logic  take;

  // control word for the current step
  always_comb begin
    ctrl = ucode_rom(step);
  end

  // jump condition and next step
  always_comb begin
    case (ctrl.cond)
      COND_NEVER:    take = 1'b0;
      COND_NO_REQ:   take = !stat.req_valid;
      COND_READ:     take = stat.is_read;
      COND_BAD:      take = stat.is_bad;
      COND_DIV_MORE: take = stat.div_more;
      COND_OUT_BUSY: take = stat.out_busy;
      default:       take = 1'b0;
    endcase
    step_next = take ? ctrl.jump : ctrl.next;
  end

  // step register
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/grade_histogram_binner_top.sv
// grade histogram binner: top level with datapath, bin store and sequencer
// a record runs dispatch, check, divide, address, update and emit; a read or bad grade skips the divide
// throughput: one request at a time; a grade goes through the 7-step shared divider
//   plus the bin store read-modify-write, and a stalled response holds the sequencer in emit
// the response register holds a finished result while the next request is taken
// reset: synchronous, clears valid bits of all bins, line count and num_bins to 10
`default_nettype none
module grade_histogram_binner_top
  import ghb_pkg::*;
#(
  parameter int MAX_BINS    = 128,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [BIN_W-1:0] cfg_wdata,
  ghb_stream_if.sink            req,
  ghb_stream_if.source          rsp
);

  localparam int USED_BINS = (MAX_BINS < GRADE_TOP) ? MAX_BINS : GRADE_TOP;
  localparam int AW        = $clog2(USED_BINS);

  ctrl_t                  ctrl;
  seq_stat_t              stat;
  logic [BIN_W-1:0]       num_bins;
  logic [BIN_W-1:0]       nb_floor;
  logic [BIN_W-1:0]       nb;
  logic [BIN_W-1:0]       nb_m1;
  req_t                   req_q;
  logic                   grade_bad;
  logic                   grade_top;
  logic [DIV_W-1:0]       quotient;
  logic                   div_more;
  logic [BIN_W-1:0]       bin_clamped;
  logic [BIN_W-1:0]       idx_q;
  logic [LINE_W-1:0]      lines_seen;
  logic [USED_BINS-1:0]   bin_valid;
  logic [AW-1:0]          raddr;
  logic [COUNT_WIDTH-1:0] rdata;
  logic [COUNT_WIDTH-1:0] cnt_old;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [63:0]            cnt_wide;
  logic [OUT_COUNT_W-1:0] cnt_out;
  logic                   sel_used;
  logic [COUNT_WIDTH-1:0] cnt_read;
  logic [63:0]            rd_wide;
  logic [OUT_COUNT_W-1:0] rd_out;
  logic                   wr_en;
  rsp_t                   res_q;
  rsp_t                   out_q;
  logic                   out_valid;
  logic                   out_busy;

  // bin count register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins <= NUM_BINS_RESET;
    end else if (cfg_we) begin
      num_bins <= cfg_wdata;
    end
  end

  // bins in use, limited to 1 .. min(100, MAX_BINS)
  always_comb begin
    nb_floor = (num_bins == '0) ? BIN_W'(1) : num_bins;
    nb       = (nb_floor > BIN_W'(USED_BINS)) ? BIN_W'(USED_BINS) : nb_floor;
    nb_m1    = nb - BIN_W'(1);
  end

  // request capture
  assign req.ready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (req.valid && ctrl.in_ready) begin
      req_q <= req.payload;
    end
  end

  // grade classification
  always_comb begin
    grade_bad = (req_q.grade < 16'sd0) ||
                (req_q.grade > $signed(GRADE_W'(GRADE_TOP)));
    grade_top = (req_q.grade == $signed(GRADE_W'(GRADE_TOP)));
  end

  // shared divider: grade / bin width
  ghb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .init     (ctrl.div_init),
    .step     (ctrl.div_step),
    .dividend (req_q.grade[DIV_W-1:0]),
    .divisor  (bin_width(nb)),
    .quotient (quotient),
    .more     (div_more)
  );

  // top grade and overrun go to the last bin
  assign bin_clamped = (grade_top || (quotient > nb_m1)) ? nb_m1 : quotient;

  // bin index register
  always_ff @(posedge clk) begin
    case (ctrl.idx_load)
      IDX_BIN: idx_q <= bin_clamped;
      IDX_SEL: idx_q <= req_q.bin_select;
      default: idx_q <= idx_q;
    endcase
  end

  // line counter, record requests only
  always_ff @(posedge clk) begin
    if (rst) begin
      lines_seen <= '0;
    end else if (ctrl.line_inc && !req_q.mode && (lines_seen != '1)) begin
      lines_seen <= lines_seen + 1'b1;
    end
  end

  // bin store
  assign raddr = (ctrl.idx_load == IDX_SEL) ? req_q.bin_select[AW-1:0]
                                            : bin_clamped[AW-1:0];
  assign wr_en = (ctrl.res == RES_GRADE);

  ghb_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (USED_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_q[AW-1:0]),
    .wdata (cnt_new),
    .raddr (raddr),
    .rdata (rdata)
  );

  // per-bin valid bits, an unwritten bin reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (wr_en) begin
      bin_valid[idx_q[AW-1:0]] <= 1'b1;
    end
  end

  // saturating increment and read-back
  always_comb begin
    cnt_old  = bin_valid[idx_q[AW-1:0]] ? rdata : '0;
    cnt_new  = (&cnt_old) ? cnt_old : cnt_old + 1'b1;
    cnt_wide = 64'(cnt_new);
    cnt_out  = (|cnt_wide[63:OUT_COUNT_W]) ? '1 : cnt_wide[OUT_COUNT_W-1:0];
    sel_used = (idx_q < nb);
    cnt_read = (sel_used && bin_valid[idx_q[AW-1:0]]) ? rdata : '0;
    rd_wide  = 64'(cnt_read);
    rd_out   = (|rd_wide[63:OUT_COUNT_W]) ? '1 : rd_wide[OUT_COUNT_W-1:0];
  end

  // result register
  always_ff @(posedge clk) begin
    case (ctrl.res)
      RES_GRADE: begin
        res_q.status      <= ST_OK;
        res_q.bin_index   <= idx_q;
        res_q.bin_count   <= cnt_out;
        res_q.line_number <= lines_seen;
      end
      RES_READ: begin
        res_q.status      <= sel_used ? ST_OK : ST_UNUSED_BIN;
        res_q.bin_index   <= idx_q;
        res_q.bin_count   <= rd_out;
        res_q.line_number <= lines_seen;
      end
      RES_BAD: begin
        res_q.status      <= ST_BAD_GRADE;
        res_q.bin_index   <= '0;
        res_q.bin_count   <= '0;
        res_q.line_number <= lines_seen;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  // response output register
  assign out_busy = out_valid && !rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit && !out_busy) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && !out_busy) begin
      out_q <= res_q;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_q;

  // sequencer
  always_comb begin
    stat.req_valid = req.valid;
    stat.is_read   = req_q.mode;
    stat.is_bad    = grade_bad;
    stat.div_more  = div_more;
    stat.out_busy  = out_busy;
  end

  ghb_useq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/ghb_checker.sv
// port-level checks for the grade histogram binner, bound to the top level
`default_nettype none
module ghb_checker
  import ghb_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   req_valid,
  input wire logic                   req_ready,
  input wire logic                   rsp_valid,
  input wire logic                   rsp_ready,
  input wire logic [1:0]             rsp_status,
  input wire logic [BIN_W-1:0]       rsp_bin_index,
  input wire logic [OUT_COUNT_W-1:0] rsp_bin_count,
  input wire logic [LINE_W-1:0]      rsp_line_number
);

  // a stalled response keeps its contents
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_bin_count) && $stable(rsp_bin_index) && $stable(rsp_line_number))
    else $error("response changed while stalled");

  // one request at a time: no new request right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one still in work");

  // bad grade reports bin zero with zero count
  a_bad_grade: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_BAD_GRADE) |-> (rsp_bin_index == '0) &&
      (rsp_bin_count == '0))
    else $error("bad grade response carries a bin");

  // unused bin read returns zero, status is a known code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_BAD_GRADE) ||
      ((rsp_status == ST_UNUSED_BIN) && (rsp_bin_count == '0)))
    else $error("bad status or nonzero count for unused bin");

endmodule

bind grade_histogram_binner_top ghb_checker u_ghb_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.payload.status),
  .rsp_bin_index   (rsp.payload.bin_index),
  .rsp_bin_count   (rsp.payload.bin_count),
  .rsp_line_number (rsp.payload.line_number)
);
`default_nettype wire

FILE: dv/tb_top.sv
// self-checking testbench for the grade histogram binner: directed and random requests
`timescale 1ns / 100ps
module tb_top;
  import ghb_pkg::*;

  localparam int HIST_BINS    = 128;
  localparam int CLK_HALF     = 5;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASES       = 11;
  localparam int RANDOM_ITEMS = 39;
  localparam int MAX_REPORTS  = 10;

  // request kinds
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_READ   = 1'b1;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [BIN_W-1:0] cfg_wdata;

  ghb_stream_if #(.T(req_t)) req_if ();
  ghb_stream_if #(.T(rsp_t)) rsp_if ();

  grade_histogram_binner_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  // predictor state
  logic [OUT_COUNT_W-1:0] bin_tally [HIST_BINS];
  logic [LINE_W-1:0]      lines_recorded;
  logic [BIN_W-1:0]       bins_cfg;

  req_t grade_requests[$];
  rsp_t pending_results[$];

  int   send_idle_pct;
  int   recv_stall_pct;
  bit   req_taken;
  bit   hold_armed;
  bit   hold_used;
  int   hold_count;
  int   mismatches;
  int   quiet_cycles;

  // clock
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // bins actually in use for the current setting
  function automatic int bins_used();
    int n;
    n = int'(bins_cfg);
    if (n < 1) n = 1;
    if (n > GRADE_TOP) n = GRADE_TOP;
    if (n > HIST_BINS) n = HIST_BINS;
    return n;
  endfunction

  // expected response for one accepted request, updating the bin tallies
  function automatic rsp_t histogram_predict(input req_t r);
    rsp_t o;
    int   nb;
    int   g;
    int   bin;
    o.status    = ST_OK;
    o.bin_index = '0;
    o.bin_count = '0;
    nb = bins_used();
    g  = {{16{r.grade[GRADE_W-1]}}, r.grade};
    if (r.mode == MODE_RECORD) begin
      if (lines_recorded != '1) lines_recorded = lines_recorded + 1'b1;
      if (g < 0 || g > GRADE_TOP) begin
        o.status = ST_BAD_GRADE;
      end else begin
        bin = (g == GRADE_TOP) ? nb - 1 : g / (GRADE_TOP / nb);
        if (bin > nb - 1) bin = nb - 1;
        if (bin_tally[bin] != '1) bin_tally[bin] = bin_tally[bin] + 1'b1;
        o.bin_index = BIN_W'(bin);
        o.bin_count = bin_tally[bin];
      end
    end else begin
      o.bin_index = r.bin_select;
      if (int'(r.bin_select) < nb) o.bin_count = bin_tally[r.bin_select];
      else o.status = ST_UNUSED_BIN;
    end
    o.line_number = lines_recorded;
    return o;
  endfunction

  function automatic req_t grade_item(input logic m, input int g, input int sel);
    req_t r;
    r.mode       = m;
    r.grade      = GRADE_W'(g);
    r.bin_select = BIN_W'(sel);
    return r;
  endfunction

  // mostly valid grades and in-use reads, some bad grades and unused bins
  function automatic req_t random_item();
    req_t r;
    int   roll;
    roll = $urandom_range(99);
    r = grade_item(MODE_RECORD, $urandom_range(GRADE_TOP), $urandom_range(127));
    if (roll >= 55 && roll < 62) begin
      r.grade = GRADE_W'($urandom);
    end else if (roll >= 62 && roll < 65) begin
      r.grade = ($urandom_range(1) == 0) ? -16'sd1 : 16'sd101;
    end else if (roll >= 65 && roll < 90) begin
      r.mode       = MODE_READ;
      r.grade      = GRADE_W'($urandom);
      r.bin_select = BIN_W'($urandom_range(bins_used() - 1));
    end else if (roll >= 90) begin
      r.mode  = MODE_READ;
      r.grade = GRADE_W'($urandom);
    end
    return r;
  endfunction

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (grade_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.valid   <= 1'b1;
        req_if.payload <= grade_requests.pop_front();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // response acceptor with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_armed && !hold_used) begin
      hold_used    <= 1'b1;
      hold_count   <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else if (hold_count > 0) begin
      hold_count   <= hold_count - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: check responses, predict accepted requests
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    req_taken = !rst && req_if.valid && req_if.ready;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected response status=%0d bin=%0d count=%0d line=%0d",
                   $realtime, got.status, got.bin_index, got.bin_count, got.line_number);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.bin_index != want.bin_index ||
            got.bin_count != want.bin_count || got.line_number != want.line_number) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch exp status=%0d bin=%0d count=%0d line=%0d, got status=%0d bin=%0d count=%0d line=%0d",
                     $realtime, want.status, want.bin_index, want.bin_count,
                     want.line_number, got.status, got.bin_index, got.bin_count,
                     got.line_number);
        end
      end
    end
    if (req_taken) pending_results.push_back(histogram_predict(req_if.payload));
  end

  // watchdog on cycles with no request or response moving
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    int cfg_plan [PHASES];
    int p;
    int i;
    cfg_plan = '{10, 0, 1, 3, 7, 33, 64, 100, 101, 127, 50};
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    req_taken      = 1'b0;
    hold_armed     = 1'b0;
    hold_used      = 1'b0;
    hold_count     = 0;
    mismatches     = 0;
    quiet_cycles   = 0;
    lines_recorded = '0;
    bins_cfg       = NUM_BINS_RESET;
    for (i = 0; i < HIST_BINS; i++) bin_tally[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      // phase 0 runs on the reset setting
      if (p != 0) begin
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= BIN_W'(cfg_plan[p]);
        bins_cfg   = BIN_W'(cfg_plan[p]);
        @(negedge clk);
        cfg_we <= 1'b0;
      end
      @(posedge clk);
      if (p < 4) begin
        send_idle_pct  = 25;
        recv_stall_pct = 80;
      end else if (p < 8) begin
        send_idle_pct  = 80;
        recv_stall_pct = 25;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (p == 8) hold_armed = 1'b1;

      if (p == 0) begin
        // bin edges, grade 100, bad grades and field extremes
        grade_requests.push_back(grade_item(MODE_RECORD, 0, 0));
        grade_requests.push_back(grade_item(MODE_RECORD, 9, 127));
        grade_requests.push_back(grade_item(MODE_RECORD, 10, 0));
        grade_requests.push_back(grade_item(MODE_RECORD, 99, 0));
        grade_requests.push_back(grade_item(MODE_RECORD, 100, 0));
        grade_requests.push_back(grade_item(MODE_RECORD, 100, 0));
        grade_requests.push_back(grade_item(MODE_RECORD, 50, 0));
        grade_requests.push_back(grade_item(MODE_RECORD, -1, 0));
        grade_requests.push_back(grade_item(MODE_RECORD, 101, 0));
        grade_requests.push_back(grade_item(MODE_RECORD, -32768, 0));
        grade_requests.push_back(grade_item(MODE_RECORD, 32767, 127));
        grade_requests.push_back(grade_item(MODE_RECORD, 1, 0));
        // read-back of used, empty and unused bins
        grade_requests.push_back(grade_item(MODE_READ, 0, 0));
        grade_requests.push_back(grade_item(MODE_READ, -1, 9));
        grade_requests.push_back(grade_item(MODE_READ, 0, 5));
        grade_requests.push_back(grade_item(MODE_READ, 0, 1));
        grade_requests.push_back(grade_item(MODE_READ, 0, 10));
        grade_requests.push_back(grade_item(MODE_READ, -32768, 127));
        grade_requests.push_back(grade_item(MODE_READ, 32767, 64));
        grade_requests.push_back(grade_item(MODE_RECORD, 95, 64));
        grade_requests.push_back(grade_item(MODE_READ, 0, 9));
        grade_requests.push_back(grade_item(MODE_RECORD, 100, 0));
      end else begin
        // counts survive a bin count change
        grade_requests.push_back(grade_item(MODE_READ, 0, 0));
        grade_requests.push_back(grade_item(MODE_RECORD, 100, 0));
      end
      for (i = 0; i < RANDOM_ITEMS; i++) grade_requests.push_back(random_item());

      // drain before the next setting
      do @(posedge clk);
      while (grade_requests.size() != 0 || req_if.valid || pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ghb_pkg.sv
hw/rtl/ghb_if.sv
hw/rtl/ghb_ram.sv
hw/rtl/ghb_div.sv
hw/rtl/ghb_useq.sv
hw/rtl/grade_histogram_binner_top.sv
hw/rtl/ghb_checker.sv
dv/tb_top.sv
